@@ hdl/cm_pkg.sv @@
// ----------------------------------------------------------------------------
// cm_pkg: shared types and constants for the complex magnitude block
// width of the magnitude result and the status word of the internal queues
// ----------------------------------------------------------------------------
package cm_pkg;

	// magnitude result width, unsigned with fraction bits
	localparam int unsigned MAG_BITS = 48;

	// queue status seen by the producer and the consumer side
	typedef struct packed {
		logic full;
		logic empty;
	} cm_qstat_t;

endpackage

@@ hdl/complex_magnitude.sv @@
// ----------------------------------------------------------------------------
// complex_magnitude: magnitude of a complex sample, floor(|z| * 2^FRACTION_BITS)
// throughput one request per cycle while full is low; each result passes through the
// four front stages, the middle queue, the one-bit-per-stage square root pipeline
// and the result queue before it shows on the ports;
// either side may stall, 4-entry queues decouple them
// asynchronous active-low reset empties both queues and clears all valid bits
// ----------------------------------------------------------------------------
module complex_magnitude #(
	parameter int COMPONENT_WIDTH = 32,
	parameter int FRACTION_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [COMPONENT_WIDTH-1:0]   real_part,
	input  logic signed [COMPONENT_WIDTH-1:0]   imag_part,
	output logic                                empty,
	input  logic                                pop,
	output logic [cm_pkg::MAG_BITS-1:0]         magnitude
);
	import cm_pkg::*;

	cm_qstat_t                       mid_stat;
	logic                            mid_wr;
	logic                            mid_rd;
	logic [2*COMPONENT_WIDTH-1:0]    mid_wdata;
	logic [2*COMPONENT_WIDTH-1:0]    mid_rdata;

	// intake and sum of squares
	cm_front #(
		.CW (COMPONENT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.real_part (real_part),
		.imag_part (imag_part),
		.mid_stat  (mid_stat),
		.mid_wr    (mid_wr),
		.mid_data  (mid_wdata)
	);

	// queue between front and back
	cm_fifo #(
		.WIDTH (2 * COMPONENT_WIDTH),
		.DEPTH (4)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_wdata),
		.rd_en   (mid_rd),
		.rd_data (mid_rdata),
		.stat    (mid_stat)
	);

	// square root and results
	cm_back #(
		.CW (COMPONENT_WIDTH),
		.F  (FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_stat  (mid_stat),
		.mid_rd    (mid_rd),
		.mid_data  (mid_rdata),
		.empty     (empty),
		.pop       (pop),
		.magnitude (magnitude)
	);

endmodule

@@ hdl/cm_fifo.sv @@
// ----------------------------------------------------------------------------
// cm_fifo: small register queue
// first-in first-out buffer of flip-flops, depth a power of two, read data
// taken straight from the head entry
// ----------------------------------------------------------------------------
module cm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [WIDTH-1:0]       wr_data,
	input  logic                   rd_en,
	output logic [WIDTH-1:0]       rd_data,
	output cm_pkg::cm_qstat_t      stat
);
	import cm_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	cm_qstat_t        stat_w;

	// status from the fill count
	always_comb begin
		stat_w.full  = (count_q == (AW+1)'(DEPTH));
		stat_w.empty = (count_q == '0);
	end
	assign stat    = stat_w;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// no write into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !stat_w.full)
		else $error("write into full queue");

	// no read from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !stat_w.empty)
		else $error("read from empty queue");

	// a lone write grows the fill count by one
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fill count did not follow write");

endmodule

@@ hdl/cm_front.sv @@
// ----------------------------------------------------------------------------
// cm_front: request intake and sum of squares
// takes each request, forms the absolute values of both parts and their
// exact sum of squares through split multipliers, then hands it to the queue
// ----------------------------------------------------------------------------
module cm_front #(
	parameter int CW = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic signed [CW-1:0]   real_part,
	input  logic signed [CW-1:0]   imag_part,
	input  cm_pkg::cm_qstat_t      mid_stat,
	output logic                   mid_wr,
	output logic [2*CW-1:0]        mid_data
);
	import cm_pkg::*;

	// operand halves for the split squares
	localparam int HL = (CW + 1) / 2;
	localparam int HH = CW - HL;

	logic adv;

	logic            vld_s1;
	logic [CW-1:0]   re_s1;
	logic [CW-1:0]   im_s1;

	logic              vld_s2;
	logic [2*HL-1:0]   re_ll_s2;
	logic [2*HH-1:0]   re_hh_s2;
	logic [HH+HL-1:0]  re_hl_s2;
	logic [2*HL-1:0]   im_ll_s2;
	logic [2*HH-1:0]   im_hh_s2;
	logic [HH+HL-1:0]  im_hl_s2;

	logic            vld_s3;
	logic [2*CW-1:0] re_sq_s3;
	logic [2*CW-1:0] im_sq_s3;

	logic            vld_s4;
	logic [2*CW-1:0] sum_s4;

	function automatic logic [CW-1:0] abs_f(input logic [CW-1:0] v);
		return v[CW-1] ? ((~v) + {{(CW-1){1'b0}}, 1'b1}) : v;
	endfunction

	// whole front moves only while the queue has room
	assign adv      = !mid_stat.full;
	assign full     = mid_stat.full;
	assign mid_wr   = adv & vld_s4;
	assign mid_data = sum_s4;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// absolute values, partial products, squares, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			re_s1 <= abs_f(real_part);
			im_s1 <= abs_f(imag_part);

			re_ll_s2 <= re_s1[HL-1:0] * re_s1[HL-1:0];
			re_hh_s2 <= re_s1[CW-1:HL] * re_s1[CW-1:HL];
			re_hl_s2 <= re_s1[CW-1:HL] * re_s1[HL-1:0];
			im_ll_s2 <= im_s1[HL-1:0] * im_s1[HL-1:0];
			im_hh_s2 <= im_s1[CW-1:HL] * im_s1[CW-1:HL];
			im_hl_s2 <= im_s1[CW-1:HL] * im_s1[HL-1:0];

			re_sq_s3 <= {re_hh_s2, {(2*HL){1'b0}}}
				+ {{(HH-1){1'b0}}, re_hl_s2, {(HL+1){1'b0}}}
				+ {{(2*HH){1'b0}}, re_ll_s2};
			im_sq_s3 <= {im_hh_s2, {(2*HL){1'b0}}}
				+ {{(HH-1){1'b0}}, im_hl_s2, {(HL+1){1'b0}}}
				+ {{(2*HH){1'b0}}, im_ll_s2};

			sum_s4 <= re_sq_s3 + im_sq_s3;
		end
	end

endmodule

@@ hdl/cm_back.sv @@
// ----------------------------------------------------------------------------
// cm_back: square root pipeline and result queue
// restoring digit-by-digit square root, one root bit per stage, on the sum
// of squares scaled by the fraction bits; results wait in a small queue
// ----------------------------------------------------------------------------
module cm_back #(
	parameter int CW = 32,
	parameter int F  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cm_pkg::cm_qstat_t               mid_stat,
	output logic                            mid_rd,
	input  logic [2*CW-1:0]                 mid_data,
	output logic                            empty,
	input  logic                            pop,
	output logic [cm_pkg::MAG_BITS-1:0]     magnitude
);
	import cm_pkg::*;

	localparam int RW   = CW + F;
	localparam int NW   = 2 * RW;
	localparam int REMW = RW + 1;
	localparam int CURW = RW + 3;

	logic              adv;
	cm_qstat_t         out_stat;
	logic [NW-1:0]     num0;
	logic [MAG_BITS-1:0] mag_res;

	logic              vld_s  [RW];
	logic [REMW-1:0]   rem_s  [RW];
	logic [RW-1:0]     root_s [RW];
	logic [NW-1:0]     num_s  [RW];

	// root pipeline moves only while the result queue has room
	assign adv    = !out_stat.full;
	assign mid_rd = adv & !mid_stat.empty;
	assign num0   = NW'(mid_data) << (2 * F);
	assign empty  = out_stat.empty;

	// one root bit per stage
	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic            vld_in;
		logic [REMW-1:0] rem_in;
		logic [RW-1:0]   root_in;
		logic [NW-1:0]   num_in;
		logic [CURW-1:0] cur;
		logic [CURW-1:0] trial;
		logic [CURW-1:0] diff;
		logic            take;

		if (k == 0) begin : g_first
			assign vld_in  = !mid_stat.empty;
			assign rem_in  = '0;
			assign root_in = '0;
			assign num_in  = num0;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign num_in  = num_s[k-1];
		end

		// bring down two bits, try root*4+1
		always_comb begin
			cur   = {rem_in, num_in[NW-1 -: 2]};
			trial = {1'b0, root_in, 2'b01};
			diff  = cur - trial;
			take  = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= take ? diff[REMW-1:0] : cur[REMW-1:0];
				root_s[k] <= {root_in[RW-2:0], take};
				num_s[k]  <= num_in << 2;
			end
		end
	end

	// fit the root into the result field, saturating when too wide
	if (RW > MAG_BITS) begin : g_sat
		assign mag_res = (|root_s[RW-1][RW-1:MAG_BITS]) ? '1 : root_s[RW-1][MAG_BITS-1:0];
	end else begin : g_ext
		assign mag_res = MAG_BITS'(root_s[RW-1]);
	end

	// result queue
	cm_fifo #(
		.WIDTH (MAG_BITS),
		.DEPTH (4)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (adv & vld_s[RW-1]),
		.wr_data (mag_res),
		.rd_en   (pop & !out_stat.empty),
		.rd_data (magnitude),
		.stat    (out_stat)
	);

endmodule
